FILE: src/dmwbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared types, constants and codes of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

    localparam int WORD_BYTES_DEF   = 4;
    localparam int BLOCK_BYTES_DEF  = 64;
    localparam int LINES_DEF        = 256;
    localparam int MEMORY_BYTES_DEF = 65536;

    localparam int FUNC_W = 2;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 32;
    localparam int LAT_W  = 16;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    localparam logic [CFG_IDX_W-1:0] CFG_MEM_RD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_RD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WR = 2'd3;

    // Which latency register to add to the time total.
    typedef enum logic [2:0] {
        ADD_NONE     = 3'd0,
        ADD_MEM_RD   = 3'd1,
        ADD_MEM_WR   = 3'd2,
        ADD_CACHE_RD = 3'd3,
        ADD_CACHE_WR = 3'd4
    } t_add_sel;

    // Controller -> datapath commands.
    typedef struct packed {
        logic       latch;       // capture the input item
        logic       tag_wr;      // write tag/valid/dirty of current line
        logic       new_valid;
        logic       new_dirty;
        logic       new_tag;     // 1: tag from request, 0: keep
        logic       clr_cnt;     // clear the word counter
        logic       inc_cnt;     // advance the word counter
        logic       line_rd_cnt; // read line word at counter
        logic       line_rd_req; // read line word at request offset
        logic       line_wr_fill;// write fill word at counter - 1
        logic       line_wr_req; // write request word at request offset
        logic       mem_rd_cnt;  // read backing word of new block at counter
        logic       mem_wr_vic;  // write victim word at counter - 1
        logic       clr_sweep;   // write zero at sweep address
        t_add_sel   add_sel;
        logic       time_clr;
        logic       set_hit;
        logic       set_wb;
        logic       set_err;
        logic       set_rdata;   // take line read data as result
        logic       clr_flags;
        logic       out_load;    // present result
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        t_func func;
        logic  addr_err;
        logic  hit;
        logic  victim_dirty;
        logic  cnt_last;     // counter at final word
        logic  cnt_done;     // counter past final word
        logic  sweep_last;
    } t_stat;

endpackage

FILE: src/direct_mapped_write_back_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_top
// Direct-mapped write-back cache with internal backing memory and time total.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request item: func, address, write_data. m_axis returns
//   one result item per request: read_data, hit, wrote_back, address_error,
//   elapsed_time. cfg writes a 16-bit latency register by index; the user must
//   write it only while idle, as the block does not enforce this. A read or a
//   write is looked up; on a miss a dirty victim block is first written back,
//   then the line is filled, and then the word is accessed. A time clear, the
//   unused code or an address error goes straight to the result. The line RAM
//   and the backing RAM each have a single port, one word a cycle. One item is
//   in work at a time. After reset the backing memory is cleared one word a
//   cycle, all MEM_WORDS words (16384 by default), with s_axis_tready low; cfg
//   writes are taken. A result waits in the output register while
//   m_axis_tready is low; no new item is taken until it is delivered.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_top #(
    parameter int WORD_BYTES   = dmwbc_pkg::WORD_BYTES_DEF,
    parameter int BLOCK_BYTES  = dmwbc_pkg::BLOCK_BYTES_DEF,
    parameter int LINES        = dmwbc_pkg::LINES_DEF,
    parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] address, [47:16] write_data
    input  logic [47:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_data, [63:32] elapsed_time
    output logic [63:0] m_axis_tdata,
    // [0] hit, [1] wrote_back, [2] address_error
    output logic [2:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import dmwbc_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [DATA_W-1:0] rd, et;
    logic h, wb, ae;

    assign o_cfg_ready = 1'b1;

    dmwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    dmwbc_datapath #(
        .WORD_BYTES(WORD_BYTES), .BLOCK_BYTES(BLOCK_BYTES),
        .LINES(LINES), .MEMORY_BYTES(MEMORY_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (s_axis_tuser),
        .i_address      (s_axis_tdata[15:0]),
        .i_write_data   (s_axis_tdata[47:16]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_idx      (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_read_data    (rd),
        .o_hit          (h),
        .o_wrote_back   (wb),
        .o_address_error(ae),
        .o_elapsed_time (et)
    );

    assign m_axis_tdata = {et, rd};
    assign m_axis_tuser = {ae, wb, h};
endmodule

FILE: src/dmwbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwbc_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module dmwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: src/dmwbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwbc_datapath
// Request registers, tag store, line and backing memories, time total.
// ----------------------------------------------------------------------------
module dmwbc_datapath #(
    parameter int WORD_BYTES   = dmwbc_pkg::WORD_BYTES_DEF,
    parameter int BLOCK_BYTES  = dmwbc_pkg::BLOCK_BYTES_DEF,
    parameter int LINES        = dmwbc_pkg::LINES_DEF,
    parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dmwbc_pkg::t_cmd                      i_cmd,
    output dmwbc_pkg::t_stat                     o_stat,
    input  logic [dmwbc_pkg::FUNC_W-1:0]         i_func,
    input  logic [dmwbc_pkg::ADDR_W-1:0]         i_address,
    input  logic [dmwbc_pkg::DATA_W-1:0]         i_write_data,
    input  logic                                 i_cfg_we,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dmwbc_pkg::LAT_W-1:0]          i_cfg_data,
    output logic [dmwbc_pkg::DATA_W-1:0]         o_read_data,
    output logic                                 o_hit,
    output logic                                 o_wrote_back,
    output logic                                 o_address_error,
    output logic [dmwbc_pkg::TIME_W-1:0]         o_elapsed_time
);
    import dmwbc_pkg::*;

    localparam int WPB_RAW   = BLOCK_BYTES / WORD_BYTES;
    localparam int WPB       = (WPB_RAW > 0) ? WPB_RAW : 1;
    localparam int MEM_WORDS = MEMORY_BYTES / WORD_BYTES;
    localparam int WB_W      = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int CNT_W     = $clog2(WPB + 1);
    localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int MA_W      = $clog2(MEM_WORDS);
    localparam int LA_W      = $clog2(LINES * WPB);
    localparam int BLK_SH    = $clog2(BLOCK_BYTES);
    localparam int WORD_SH   = $clog2(WORD_BYTES);
    localparam int BLK_W     = ADDR_W - BLK_SH;
    localparam int TAG_W     = (BLK_W - LINE_W > 0) ? BLK_W - LINE_W : 1;
    localparam int MAX_BLK   = MEM_WORDS / WPB;  // blocks that fit

    // Request.
    t_func                   r_func;
    logic [BLK_W-1:0]        r_block;
    logic [WB_W-1:0]         r_widx;
    logic [DATA_W-1:0]       r_wdata;
    logic                    r_err;

    // Split the incoming address: block number and word within the block.
    logic [31:0] w_in_blk;
    logic [31:0] w_in_wi;
    always_comb begin
        w_in_blk = 32'(i_address) >> BLK_SH;
        w_in_wi  = (32'(i_address) & 32'(BLOCK_BYTES - 1)) >> WORD_SH;
        if (w_in_wi >= 32'(WPB)) w_in_wi = 32'(WPB - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= t_func'(i_func);
            r_block <= BLK_W'(w_in_blk);
            r_widx  <= WB_W'(w_in_wi);
            r_wdata <= i_write_data;
            r_err   <= (w_in_blk + 32'd1) > 32'(MAX_BLK);
        end
    end

    logic [LINE_W-1:0] w_line;
    logic [TAG_W-1:0]  w_tag;
    assign w_line = r_block[LINE_W-1:0];
    assign w_tag  = TAG_W'(r_block >> LINE_W);

    // Valid bits in flops; dirty mark and tag in a RAM read at the new line
    // while the item is taken, so the lookup sees them in the next cycle.
    logic [LINES-1:0]  r_valid;
    logic              tag_we;
    logic [LINE_W-1:0] tag_addr;
    logic [TAG_W:0]    tag_wdata, tag_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.tag_wr) begin
            r_valid[w_line] <= i_cmd.new_valid;
        end
    end

    assign tag_we    = i_cmd.tag_wr;
    assign tag_addr  = i_cmd.latch ? LINE_W'(w_in_blk) : w_line;
    assign tag_wdata = {i_cmd.new_dirty, i_cmd.new_tag ? w_tag : tag_rdata[TAG_W-1:0]};

    dmwbc_ram #(.WIDTH(TAG_W + 1), .DEPTH(LINES)) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (tag_we),
        .i_addr (tag_addr),
        .i_wdata(tag_wdata),
        .o_rdata(tag_rdata)
    );

    logic [TAG_W-1:0] w_vtag;
    assign w_vtag = tag_rdata[TAG_W-1:0];

    // Word counter.
    logic [CNT_W-1:0] r_cnt;
    logic [WB_W-1:0]  w_cnt_prev;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_cmd.inc_cnt) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end
    assign w_cnt_prev = WB_W'(r_cnt - 1'b1);

    // Sweep counter for backing memory clear.
    logic [MA_W-1:0] r_sweep;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.clr_sweep) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    // Line memory.
    logic              line_we;
    logic [LA_W-1:0]   line_addr;
    logic [DATA_W-1:0] line_wdata, line_rdata;
    logic [DATA_W-1:0] mem_rdata;

    always_comb begin
        line_we    = i_cmd.line_wr_fill | i_cmd.line_wr_req;
        line_wdata = i_cmd.line_wr_fill ? mem_rdata : r_wdata;
        if (i_cmd.line_wr_fill) begin
            line_addr = LA_W'(w_line * WPB + w_cnt_prev);
        end else if (i_cmd.line_rd_cnt) begin
            line_addr = LA_W'(w_line * WPB + WB_W'(r_cnt));
        end else begin
            line_addr = LA_W'(w_line * WPB + r_widx);
        end
    end

    dmwbc_ram #(.WIDTH(DATA_W), .DEPTH(LINES * WPB)) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (line_we),
        .i_addr (line_addr),
        .i_wdata(line_wdata),
        .o_rdata(line_rdata)
    );

    // Backing memory.
    logic            mem_we;
    logic [MA_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [31:0]     vbase;
    always_comb begin
        vbase     = (32'(w_vtag) * LINES + 32'(w_line)) * WPB;
        mem_we    = i_cmd.mem_wr_vic | i_cmd.clr_sweep;
        mem_wdata = i_cmd.clr_sweep ? '0 : line_rdata;
        if (i_cmd.clr_sweep) begin
            mem_addr = r_sweep;
        end else if (i_cmd.mem_wr_vic) begin
            mem_addr = MA_W'(vbase + 32'(w_cnt_prev));
        end else begin
            mem_addr = MA_W'(32'(r_block) * WPB + 32'(r_cnt));
        end
    end

    dmwbc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // Latency registers and time total.
    logic [LAT_W-1:0]  r_lat [4];
    logic [TIME_W-1:0] r_time;
    logic [LAT_W-1:0]  add_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat[CFG_MEM_RD]   <= LAT_W'(100);
            r_lat[CFG_MEM_WR]   <= LAT_W'(50);
            r_lat[CFG_CACHE_RD] <= LAT_W'(1);
            r_lat[CFG_CACHE_WR] <= LAT_W'(1);
        end else if (i_cfg_we) begin
            r_lat[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        case (i_cmd.add_sel)
            ADD_MEM_RD:   add_val = r_lat[CFG_MEM_RD];
            ADD_MEM_WR:   add_val = r_lat[CFG_MEM_WR];
            ADD_CACHE_RD: add_val = r_lat[CFG_CACHE_RD];
            ADD_CACHE_WR: add_val = r_lat[CFG_CACHE_WR];
            default:      add_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.time_clr) begin
            r_time <= '0;
        end else begin
            r_time <= r_time + TIME_W'(add_val);
        end
    end

    // Result flags.
    logic              r_hit, r_wb, r_aerr;
    logic [DATA_W-1:0] r_rd;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_flags) begin
            r_hit <= 1'b0; r_wb <= 1'b0; r_aerr <= 1'b0; r_rd <= '0;
        end else begin
            if (i_cmd.set_hit)   r_hit  <= 1'b1;
            if (i_cmd.set_wb)    r_wb   <= 1'b1;
            if (i_cmd.set_err)   r_aerr <= 1'b1;
            if (i_cmd.set_rdata) r_rd   <= line_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_read_data     <= r_rd;
            o_hit           <= r_hit;
            o_wrote_back    <= r_wb;
            o_address_error <= r_aerr;
            o_elapsed_time  <= r_time;
        end
    end

    always_comb begin
        o_stat.func         = r_func;
        o_stat.addr_err     = r_err;
        o_stat.hit          = r_valid[w_line] && (tag_rdata[TAG_W-1:0] == w_tag);
        o_stat.victim_dirty = r_valid[w_line] && tag_rdata[TAG_W];
        o_stat.cnt_last     = (r_cnt == CNT_W'(WPB - 1));
        o_stat.cnt_done     = (r_cnt == CNT_W'(WPB));
        o_stat.sweep_last   = (r_sweep == MA_W'(MEM_WORDS - 1));
    end
endmodule

FILE: src/dmwbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwbc_ctrl
// Sequencer: clear sweep, lookup, write-back, fill, access and result.
// ----------------------------------------------------------------------------
module dmwbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dmwbc_pkg::t_cmd  o_cmd,
    input  dmwbc_pkg::t_stat i_stat
);
    import dmwbc_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_LOOKUP = 9'b000000100,
        S_WB     = 9'b000001000,
        S_FILL   = 9'b000010000,
        S_ACCESS = 9'b000100000,
        S_RDWAIT = 9'b001000000,
        S_DONE   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // First cycle of a write-back or fill has no read data yet.
    logic first_wb, first_fill;
    logic r_prev_wb, r_prev_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd   = '0;
        o_cmd.add_sel = ADD_NONE;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch     = 1'b1;
                    o_cmd.clr_flags = 1'b1;
                    n_state         = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.clr_cnt = 1'b1;
                if (i_stat.func == FUNC_CLEAR) begin
                    o_cmd.time_clr = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.func == FUNC_NONE) begin
                    n_state = S_DONE;
                end else if (i_stat.addr_err) begin
                    o_cmd.set_err = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.hit) begin
                    o_cmd.set_hit     = 1'b1;
                    o_cmd.line_rd_req = 1'b1;
                    n_state = S_ACCESS;
                end else begin
                    o_cmd.add_sel     = ADD_MEM_RD;
                    o_cmd.line_rd_cnt = 1'b1;
                    n_state = i_stat.victim_dirty ? S_WB : S_FILL;
                end
            end
            S_WB: begin
                // Line word at counter-1 is on the read port; store it.
                o_cmd.inc_cnt     = 1'b1;
                o_cmd.line_rd_cnt = 1'b1;
                if (i_stat.cnt_last) begin
                    o_cmd.add_sel = ADD_MEM_WR;
                    o_cmd.set_wb  = 1'b1;
                end
                if (!i_stat.cnt_done) begin
                    o_cmd.mem_wr_vic = (r_state == S_WB) && (i_stat.cnt_done == 1'b0)
                                       && !first_wb;
                end
                if (i_stat.cnt_done) begin
                    o_cmd.inc_cnt    = 1'b0;
                    o_cmd.mem_wr_vic = 1'b1;
                    o_cmd.clr_cnt    = 1'b1;
                    o_cmd.set_wb     = 1'b0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.mem_rd_cnt = 1'b1;
                o_cmd.inc_cnt    = 1'b1;
                o_cmd.line_wr_fill = !first_fill;
                if (i_stat.cnt_done) begin
                    o_cmd.inc_cnt = 1'b0;
                    o_cmd.tag_wr    = 1'b1;
                    o_cmd.new_valid = 1'b1;
                    o_cmd.new_dirty = 1'b0;
                    o_cmd.new_tag   = 1'b1;
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                if (i_stat.func == FUNC_READ) begin
                    o_cmd.line_rd_req = 1'b1;
                    o_cmd.add_sel     = ADD_CACHE_RD;
                    n_state = S_RDWAIT;
                end else begin
                    o_cmd.line_wr_req = 1'b1;
                    o_cmd.add_sel     = ADD_CACHE_WR;
                    o_cmd.tag_wr      = 1'b1;
                    o_cmd.new_valid   = 1'b1;
                    o_cmd.new_dirty   = 1'b1;
                    o_cmd.new_tag     = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                o_cmd.set_rdata = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_wb <= 1'b0; r_prev_fill <= 1'b0;
        end else begin
            r_prev_wb   <= (r_state == S_WB);
            r_prev_fill <= (r_state == S_FILL);
        end
    end
    assign first_wb   = !r_prev_wb;
    assign first_fill = !r_prev_fill;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result pending");
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_LOOKUP))
        else $error("accepted item not looked up");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn");
endmodule

FILE: test/direct_mapped_write_back_cache_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_top_test
// Self-checking bench for the direct-mapped write-back cache. A behavioral
// cache model predicts every result item; results are checked field by field
// in order. Directed items cover hits, misses, dirty write-backs, the address
// limit, time clears and the unused code; random items follow, most with random
// stalls on both streams, under several latency settings.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_top_test;
    import dmwbc_pkg::*;

    localparam int WPB       = 16;
    localparam int NLINES    = 256;
    localparam int MEM_WORDS = 16384;
    localparam int LIMIT     = 3000000;

    typedef struct packed {
        logic [31:0] rdata;
        logic        hit;
        logic        wb;
        logic        aerr;
        logic [31:0] elapsed;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [15:0] address, [47:16] write_data
    logic [1:0]  s_axis_tuser;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [31:0] read_data, [63:32] elapsed_time
    logic [2:0]  m_axis_tuser;   // [0] hit, [1] wrote_back, [2] address_error
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    direct_mapped_write_back_cache_top dut (.*);

    // Predictor state: a second copy of the cache and its backing memory.
    logic [15:0] lat_mem_rd, lat_mem_wr, lat_cache_rd, lat_cache_wr;
    logic        ln_valid [NLINES];
    logic        ln_dirty [NLINES];
    logic [1:0]  ln_tag   [NLINES];
    logic [31:0] ln_word  [NLINES*WPB];
    logic [31:0] mem_word [MEM_WORDS];
    logic [31:0] time_sum;

    t_result expected_q[$];
    int      errors;
    int      cycles;
    bit      idle_enable;   // random stalls on both streams

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: end the run at a generous cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("direct_mapped_write_back_cache_top_test: FAIL");
            $finish;
        end
    end

    // Compute the expected result of one request and advance the model.
    function automatic t_result cache_access(t_func fn, logic [15:0] addr, logic [31:0] wd);
        t_result r;
        int blk, widx, ln, tg, base, vbase;
        r = '0;
        blk  = int'(addr) / 64;
        widx = (int'(addr) % 64) / 4;
        ln   = blk % NLINES;
        tg   = blk / NLINES;
        if (fn == FUNC_CLEAR) begin
            time_sum = '0;
        end else if (fn == FUNC_READ || fn == FUNC_WRITE) begin
            if ((blk + 1) * WPB > MEM_WORDS) begin
                r.aerr = 1'b1;
            end else begin
                if (ln_valid[ln] && ln_tag[ln] == tg) begin
                    r.hit = 1'b1;
                end else begin
                    base = blk * WPB;
                    time_sum += 32'(lat_mem_rd);
                    if (ln_valid[ln] && ln_dirty[ln]) begin
                        vbase = (int'(ln_tag[ln]) * NLINES + ln) * WPB;
                        for (int i = 0; i < WPB; i++)
                            mem_word[vbase+i] = ln_word[ln*WPB+i];
                        time_sum += 32'(lat_mem_wr);
                        r.wb = 1'b1;
                    end
                    for (int i = 0; i < WPB; i++) ln_word[ln*WPB+i] = mem_word[base+i];
                    ln_valid[ln] = 1'b1;
                    ln_tag[ln]   = tg[1:0];
                    ln_dirty[ln] = 1'b0;
                end
                if (fn == FUNC_READ) begin
                    r.rdata = ln_word[ln*WPB+widx];
                    time_sum += 32'(lat_cache_rd);
                end else begin
                    ln_word[ln*WPB+widx] = wd;
                    time_sum += 32'(lat_cache_wr);
                    ln_dirty[ln] = 1'b1;
                end
            end
        end
        r.elapsed = time_sum;
        return r;
    endfunction

    // Wait a random idle gap before presenting an item; drop valid meanwhile.
    task automatic idle_gap();
        if (idle_enable && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (idle_enable && $urandom_range(99) < 36);
        end
    endtask

    // Send one request item and queue its expected result.
    task automatic send_item(t_func fn, logic [15:0] addr, logic [31:0] wd);
        idle_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {wd, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(cache_access(fn, addr, wd));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MEM_RD:   lat_mem_rd   = val;
            CFG_MEM_WR:   lat_mem_wr   = val;
            CFG_CACHE_RD: lat_cache_rd = val;
            default:      lat_cache_wr = val;
        endcase
    endtask

    task automatic set_latencies(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                 logic [15:0] d);
        write_reg(CFG_MEM_RD, a);
        write_reg(CFG_MEM_WR, b);
        write_reg(CFG_CACHE_RD, c);
        write_reg(CFG_CACHE_WR, d);
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker and random backpressure.
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tuser[0], m_axis_tuser[1],
                       m_axis_tuser[2], m_axis_tdata[63:32]};
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.rdata !== exp_r.rdata) begin
                        $display("%0t read_data exp %h got %h", $time, exp_r.rdata, got.rdata);
                        errors++;
                    end
                    if (got.hit !== exp_r.hit) begin
                        $display("%0t hit exp %b got %b", $time, exp_r.hit, got.hit);
                        errors++;
                    end
                    if (got.wb !== exp_r.wb) begin
                        $display("%0t wrote_back exp %b got %b", $time, exp_r.wb, got.wb);
                        errors++;
                    end
                    if (got.aerr !== exp_r.aerr) begin
                        $display("%0t address_error exp %b got %b", $time, exp_r.aerr,
                                 got.aerr);
                        errors++;
                    end
                    if (got.elapsed !== exp_r.elapsed) begin
                        $display("%0t elapsed_time exp %h got %h", $time, exp_r.elapsed,
                                 got.elapsed);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !idle_enable || ($urandom_range(99) >= 36);
        end
    end

    // Directed: extremes, every func code, hits, misses and dirty evictions.
    task automatic test_directed();
        send_item(FUNC_READ, 16'h0000, 32'h0);            // cold miss
        send_item(FUNC_WRITE, 16'h0004, 32'hFFFF_FFFF);   // hit, dirty
        send_item(FUNC_READ, 16'h0007, 32'h0);            // unaligned, hit
        send_item(FUNC_WRITE, 16'hFFFC, 32'hA5A5_5A5A);   // top word
        send_item(FUNC_READ, 16'hFFFF, 32'h0);
        send_item(FUNC_READ, 16'h4000, 32'h0);            // evict dirty line 0
        send_item(FUNC_READ, 16'h0004, 32'h0);            // written-back data
        send_item(FUNC_NONE, 16'h1234, 32'hDEAD_BEEF);
        send_item(FUNC_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE, 16'h3FC0, 32'h1234_5678);
        send_item(FUNC_WRITE, 16'h7FC0, 32'h0);           // evict dirty last line
        send_item(FUNC_READ, 16'h3FC0, 32'h0);
        send_item(FUNC_NONE, 16'h0000, 32'h0);
    endtask

    // Random: mostly reads and writes over a few tags so lines collide.
    task automatic test_random(int n);
        logic [15:0] a;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            a = 16'($urandom);
            if (k < 70) a[13:6] = 8'($urandom_range(7));  // crowd a few lines
            if (k < 45) send_item(FUNC_WRITE, a, $urandom);
            else if (k < 92) send_item(FUNC_READ, a, $urandom);
            else if (k < 96) send_item(FUNC_CLEAR, a, $urandom);
            else send_item(FUNC_NONE, a, $urandom);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic test_drained_sender();
        send_item(FUNC_WRITE, 16'h0100, 32'h0BAD_F00D);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        send_item(FUNC_READ, 16'h4100, 32'h0);
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        cycles = 0;
        idle_enable = 1'b0;
        lat_mem_rd = 16'd100; lat_mem_wr = 16'd50;
        lat_cache_rd = 16'd1; lat_cache_wr = 16'd1;
        time_sum = '0;
        for (int i = 0; i < NLINES; i++) begin
            ln_valid[i] = 1'b0; ln_dirty[i] = 1'b0; ln_tag[i] = '0;
        end
        for (int i = 0; i < NLINES*WPB; i++) ln_word[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) mem_word[i] = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();              // reset latencies, no stalls
        drain();
        set_latencies(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_enable = 1'b1;
        test_random(200);
        test_drained_sender();
        drain();
        set_latencies(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        test_random(150);
        drain();
        set_latencies(16'd7, 16'd300, 16'd2, 16'd3);
        idle_enable = 1'b0;           // long stretch at full rate
        test_random(150);
        idle_enable = 1'b1;
        test_random(250);
        drain();

        if (errors == 0 && expected_q.size() == 0)
            $display("direct_mapped_write_back_cache_top_test: PASS");
        else
            $display("direct_mapped_write_back_cache_top_test: FAIL");
        $finish;
    end
endmodule

FILE: files.f
src/dmwbc_pkg.sv
src/dmwbc_ram.sv
src/dmwbc_datapath.sv
src/dmwbc_ctrl.sv
src/direct_mapped_write_back_cache_top.sv
test/direct_mapped_write_back_cache_top_test.sv
